>>> hdl/oaat_pkg.sv
// Shared types and constants for the open-addressing address table.
package oaat_pkg;

    localparam int KEY_W      = 64;
    localparam int SLOT_OUT_W = 12;
    localparam int CNT_W      = 13;

    // splitmix-style mixing constants
    localparam logic [63:0] MIX_MUL     = 64'hbf58476d1ce4e5b9;
    localparam int          MIX_SHIFT_A = 30;
    localparam int          MIX_SHIFT_B = 27;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_MARK   = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REFUSED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_UNNAMED   = 3'd4
    } status_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [KEY_W-1:0]   key;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_OUT_W-1:0]  slot;
    } rsp_t;

endpackage

>>> hdl/open_addressing_address_table_core.sv
// Open-addressing address table: hash set of 64-bit keys with linear probing.
//
// A hash set of non-zero 64-bit addresses held in a single TABLE_SIZE-entry
// synchronous RAM, each word carrying the key and its "named" flag. Each
// request transaction (insert, mark named, look up named) yields exactly one
// response transaction with a status and a slot. After reset the block first
// runs a clearing pass over all TABLE_SIZE words, one RAM word per cycle, with
// req_stall held high. A request that is refused outright (zero key, unused
// request type, insert at half load) goes straight from S_IDLE to S_RESP. Any
// other request runs from acceptance to the next acceptance through these
// steps: the 64-bit mix multiply, done as three passes through one shared
// 32x32 multiplier; S_HASH, which forms the home slot and issues the first
// read; the single RAM read port then checks one slot per cycle, n slots in
// all (at least 1); and S_RESP, which loads the response register once the
// output register is free. A finished response may sit in the output register
// while the next request is taken.
module open_addressing_address_table_core
    import oaat_pkg::*;
#(
    parameter int TABLE_SIZE = 4096
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int WORD_W = KEY_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL0  = 8'b0000_0100,
        S_MUL1  = 8'b0000_1000,
        S_MUL2  = 8'b0001_0000,
        S_HASH  = 8'b0010_0000,
        S_PROBE = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } state_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t              state_reg,     state_next;
    logic [SLOT_W-1:0]   clr_addr_reg,  clr_addr_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    req_type_t           req_type_reg,  req_type_next;
    logic [KEY_W-1:0]    key_reg,       key_next;
    logic [KEY_W-1:0]    mix_reg,       mix_next;    // key ^ (key >> 30)
    logic [63:0]         prod_lo_reg,   prod_lo_next; // low x low
    logic [31:0]         cross_reg,     cross_next;   // cross terms, low 32 bits
    logic [SLOT_W-1:0]   slot_reg,      slot_next;    // slot under probe
    logic [SLOT_W-1:0]   probe_cnt_reg, probe_cnt_next;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg,  res_slot_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,       rsp_next;

    // RAM: {named, key} per slot
    logic [WORD_W-1:0]   mem [TABLE_SIZE];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;

    // Shared 32x32 multiplier
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;

    // Hash and probe signals
    logic [63:0]         mixed;
    logic [63:0]         hashed;
    logic [SLOT_W-1:0]   home_slot;
    logic [KEY_W-1:0]    rd_key;
    logic                rd_named;
    logic                slot_empty;
    logic                slot_hit;
    logic [KEY_W-1:0]    in_mix;
    logic                half_full;
    logic                refuse_now;
    logic                rsp_free;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // RAM
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Mix datapath
    // ---------------------------------------------------------------
    // Product is only needed mod 2^64:
    //   lo*lo + ((hi*lo_m + lo*hi_m) << 32)
    always_comb
    begin
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = mix_reg[63:32];
                mul_b = MIX_MUL[31:0];
            end
            S_MUL2:
            begin
                mul_a = mix_reg[31:0];
                mul_b = MIX_MUL[63:32];
            end
            default:
            begin
                mul_a = mix_reg[31:0];
                mul_b = MIX_MUL[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign mixed     = {prod_lo_reg[63:32] + cross_reg, prod_lo_reg[31:0]};
    assign hashed    = mixed ^ (mixed >> MIX_SHIFT_B);
    assign home_slot = hashed[SLOT_W-1:0];

    assign in_mix    = req.key ^ (req.key >> MIX_SHIFT_A);
    assign half_full = (32'({count_reg, 1'b0}) >= 32'(TABLE_SIZE));

    always_comb
    begin
        refuse_now = 1'b0;
        if (req.key == '0)
        begin
            refuse_now = 1'b1;
        end
        else
        begin
            unique case (req.req_type)
                REQ_INSERT: refuse_now = half_full;
                REQ_MARK:   refuse_now = 1'b0;
                REQ_LOOKUP: refuse_now = 1'b0;
                default:    refuse_now = 1'b1;
            endcase
        end
    end

    assign rd_key     = rd_data_reg[KEY_W-1:0];
    assign rd_named   = rd_data_reg[KEY_W];
    assign slot_empty = (rd_key == '0);
    assign slot_hit   = (rd_key == key_reg);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // slot reported masked to 12 bits
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_reg};

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        req_type_next   = req_type_reg;
        key_next        = key_reg;
        mix_next        = mix_reg;
        prod_lo_next    = prod_lo_reg;
        cross_next      = cross_reg;
        slot_next       = slot_reg;
        probe_cnt_next  = probe_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {1'b0, key_reg};

        // response register drains independently of the request side
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_next = req.req_type;
                    key_next      = req.key;
                    mix_next      = in_mix;
                    if (refuse_now)
                    begin
                        res_status_next = ST_REFUSED;
                        res_slot_next   = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end

            S_MUL0:
            begin
                prod_lo_next = mul_p;
                state_next   = S_MUL1;
            end

            S_MUL1:
            begin
                cross_next = mul_p[31:0];
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                cross_next = cross_reg + mul_p[31:0];
                state_next = S_HASH;
            end

            S_HASH:
            begin
                rd_en          = 1'b1;
                rd_addr        = home_slot;
                slot_next      = home_slot;
                probe_cnt_next = '0;
                state_next     = S_PROBE;
            end

            S_PROBE:
            begin
                if (slot_empty)
                begin
                    if (req_type_reg == REQ_INSERT)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = {1'b0, key_reg};
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_DONE;
                        res_slot_next   = slot_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                    end
                    state_next = S_RESP;
                end
                else if (slot_hit)
                begin
                    res_slot_next = slot_reg;
                    unique case (req_type_reg)
                        REQ_INSERT:
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        REQ_MARK:
                        begin
                            wr_en           = 1'b1;
                            wr_data         = {1'b1, key_reg};
                            res_status_next = rd_named ? ST_PRESENT : ST_DONE;
                        end
                        default:
                        begin
                            res_status_next = rd_named ? ST_DONE : ST_UNNAMED;
                        end
                    endcase
                    state_next = S_RESP;
                end
                else if (probe_cnt_reg == LAST_SLOT)
                begin
                    // full circle with no empty slot and no match
                    res_status_next = (req_type_reg == REQ_INSERT) ? ST_REFUSED
                                                                   : ST_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_reg + 1'b1;
                    slot_next      = slot_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = res_status_reg;
                    rsp_next.slot   = slot_ext[SLOT_OUT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        key_reg        <= key_next;
        mix_reg        <= mix_next;
        prod_lo_reg    <= prod_lo_next;
        cross_reg      <= cross_next;
        slot_reg       <= slot_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_reg        <= rsp_next;
    end

endmodule
